// ----- rtl/tccr_pkg.sv -----
package tccr_pkg;

   // Field and register widths.
   localparam int CoordW    = 12;
   localparam int ScaleW    = 6;
   localparam int CharW     = 8;
   localparam int ScrollW   = 8;
   localparam int CursorW   = 24;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 12;

   // Restoring divider sizes: cursor-sized dividend, coordinate-sized divisor.
   localparam int DivDividendW = CursorW;
   localparam int DivDivisorW  = CoordW;
   localparam int DivCntW      = $clog2(DivDividendW);

   // Queue between the front and the back.
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Character codes with a meaning of their own.
   localparam logic [CharW-1:0] CharNul       = 8'd0;
   localparam logic [CharW-1:0] CharBackspace = 8'd8;
   localparam logic [CharW-1:0] CharNewline   = 8'd10;
   localparam logic [CharW-1:0] CharSpace     = 8'd32;

   // Result command codes.
   localparam logic CmdDraw   = 1'b0;
   localparam logic CmdScroll = 1'b1;

   // Register values after reset.
   localparam logic [CoordW-1:0]  ResetLeft   = 12'd10;
   localparam logic [CoordW-1:0]  ResetTop    = 12'd120;
   localparam logic [CoordW-1:0]  ResetRight  = 12'd1014;
   localparam logic [CoordW-1:0]  ResetBottom = 12'd750;
   localparam logic [ScaleW-1:0]  ResetScale  = 6'd10;
   localparam logic [CursorW-1:0] ResetCursor = 24'd0;
   localparam logic [CursorW-1:0] ResetFloor  = 24'd1;

   typedef enum logic [CsrIndexW-1:0] {
      REG_AREA_LEFT   = 3'd0,
      REG_AREA_TOP    = 3'd1,
      REG_AREA_RIGHT  = 3'd2,
      REG_AREA_BOTTOM = 3'd3,
      REG_GLYPH_SCALE = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_PRINT     = 2'd0,
      KIND_NEWLINE   = 2'd1,
      KIND_BACKSPACE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [CharW-1:0] code;
   } item_type;

   typedef struct packed {
      logic [CoordW-1:0] left;
      logic [CoordW-1:0] top;
      logic [CoordW-1:0] right;
      logic [CoordW-1:0] bottom;
      logic [ScaleW-1:0] scale;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_CFG,
      ST_POS_START,
      ST_DIV_POS,
      ST_EXEC,
      ST_SCROLL
   } back_state_type;

endpackage

// ----- rtl/tccr_front.sv -----
module tccr_front import tccr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CharW-1:0] req_char_code,
   output logic             q_push,
   output item_type         q_item,
   input  logic             q_full
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   item_type classified;

   // The holding register drains into the queue whenever the queue has room.
   assign q_push    = valid_ff && !q_full;
   assign q_item    = item_ff;
   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;

   // Sort the character into the three kinds of work the back end knows.
   always_comb begin
      classified.code = req_char_code;
      if (req_char_code == CharBackspace) begin
         classified.kind = KIND_BACKSPACE;
      end else if (req_char_code == CharNewline) begin
         classified.kind = KIND_NEWLINE;
      end else begin
         classified.kind = KIND_PRINT;
      end
   end

   // A NUL item is taken and dropped here; it never reaches the queue.
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = (req_char_code != CharNul);
         item_in  = classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ----- rtl/tccr_queue.sv -----
module tccr_queue import tccr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   item_type               entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/tccr_div.sv -----
module tccr_div import tccr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DivDividendW-1:0] dividend,
   input  logic [DivDivisorW-1:0]  divisor,
   output logic                    done,
   output logic [DivDividendW-1:0] quotient,
   output logic [DivDivisorW-1:0]  remainder
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DivCntW-1:0]      cnt_ff, cnt_in;
   logic [DivDividendW-1:0] quo_ff, quo_in;
   logic [DivDivisorW-1:0]  rem_ff, rem_in;
   logic [DivDivisorW:0]    rem_shift;
   logic [DivDivisorW:0]    rem_sub;
   logic                    fits;

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // One restoring step per cycle: the dividend shifts out of the top of the
   // quotient register while quotient bits shift in at the bottom.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DivDividendW-1]};
      rem_sub   = rem_shift - {1'b0, divisor};
      fits      = (rem_shift >= {1'b0, divisor});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[DivDivisorW-1:0] : rem_shift[DivDivisorW-1:0];
         quo_in = {quo_ff[DivDividendW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DivCntW'(DivDividendW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

// ----- rtl/tccr_back.sv -----
module tccr_back import tccr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               cfg_dirty,
   output logic               cfg_clear,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_command_kind,
   output logic [CoordW-1:0]  rsp_pos_x,
   output logic [CoordW-1:0]  rsp_pos_y,
   output logic [CharW-1:0]   rsp_glyph,
   output logic [ScaleW-1:0]  rsp_cell_size,
   output logic [ScrollW-1:0] rsp_scroll_pixels,
   output logic               rsp_last
);

   back_state_type       state_ff, state_in;
   item_type             item_ff, item_in;
   logic [CursorW-1:0]   cursor_ff, cursor_in;
   logic [CursorW-1:0]   floor_ff, floor_in;
   logic [CursorW-1:0]   row_ff, row_in;
   logic [CoordW-1:0]    col_ff, col_in;
   logic [CoordW-1:0]    cpl_ff, cpl_in;
   logic [CoordW-1:0]    lines_ff, lines_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_kind_ff, out_kind_in;
   logic [CoordW-1:0]    out_x_ff, out_x_in;
   logic [CoordW-1:0]    out_y_ff, out_y_in;
   logic [CharW-1:0]     out_glyph_ff, out_glyph_in;
   logic [ScaleW-1:0]    out_size_ff, out_size_in;
   logic [ScrollW-1:0]   out_scroll_ff, out_scroll_in;
   logic                 out_last_ff, out_last_in;

   logic [ScaleW-1:0]    scale;
   logic [ScrollW-1:0]   line_h;
   logic [CoordW-1:0]    area_w;
   logic [CoordW-1:0]    area_h;
   logic                 out_free;
   logic                 recalc;

   logic                    div_a_start;
   logic [DivDividendW-1:0] div_a_dividend;
   logic [DivDivisorW-1:0]  div_a_divisor;
   logic                    div_a_done;
   logic [DivDividendW-1:0] div_a_quo;
   logic [DivDivisorW-1:0]  div_a_rem;
   logic [DivDividendW-1:0] div_b_quo;

   logic                 is_print, is_newline, is_bs;
   logic                 bs_ok;
   logic                 col_is_zero;
   logic [CoordW-1:0]    col_dec;
   logic [CursorW-1:0]   row_dec;
   logic [CoordW-1:0]    draw_col;
   logic [CoordW-1:0]    draw_row;
   logic [CoordW+ScaleW-1:0]  prod_x;
   logic [CoordW+ScrollW-1:0] prod_y;
   logic [CoordW-1:0]    draw_x, draw_y;
   logic [CursorW:0]     inc_sum;
   logic [CursorW:0]     nl_sum;
   logic [CoordW:0]      col_inc;
   logic [CursorW-1:0]   new_cursor, new_row;
   logic [CoordW-1:0]    new_col;
   logic                 scroll_need;

   assign rsp_valid         = out_valid_ff;
   assign rsp_command_kind  = out_kind_ff;
   assign rsp_pos_x         = out_x_ff;
   assign rsp_pos_y         = out_y_ff;
   assign rsp_glyph         = out_glyph_ff;
   assign rsp_cell_size     = out_size_ff;
   assign rsp_scroll_pixels = out_scroll_ff;
   assign rsp_last          = out_last_ff;

   // Geometry that follows straight from the registers.
   assign scale    = (cfg.scale == '0) ? ScaleW'(1) : cfg.scale;
   assign line_h   = {1'b0, scale, 1'b0} + ScrollW'(2);
   assign area_w   = (cfg.right >= cfg.left) ? cfg.right - cfg.left : '0;
   assign area_h   = (cfg.bottom >= cfg.top) ? cfg.bottom - cfg.top : '0;
   assign out_free = !out_valid_ff || !rsp_stall;

   // An item is taken from the queue only when the back end is idle.
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign recalc    = q_pop && cfg_dirty;
   assign cfg_clear = recalc;

   // Divider A does chars per line, then cursor by chars per line.
   // Divider B does lines in the area alongside the first pass of A.
   assign div_a_start    = recalc || (state_ff == ST_POS_START);
   assign div_a_dividend = (state_ff == ST_POS_START) ? cursor_ff
                                                      : {{(CursorW-CoordW){1'b0}}, area_w};
   assign div_a_divisor  = ((state_ff == ST_POS_START) || (state_ff == ST_DIV_POS)) ?
                           cpl_ff : {{(CoordW-ScaleW){1'b0}}, scale};

   tccr_div u_div_a (
      .clock     (clock),
      .reset     (reset),
      .start     (div_a_start),
      .dividend  (div_a_dividend),
      .divisor   (div_a_divisor),
      .done      (div_a_done),
      .quotient  (div_a_quo),
      .remainder (div_a_rem)
   );

   tccr_div u_div_b (
      .clock     (clock),
      .reset     (reset),
      .start     (recalc),
      .dividend  ({{(CursorW-CoordW){1'b0}}, area_h}),
      .divisor   ({{(CoordW-ScrollW){1'b0}}, line_h}),
      .done      (),
      .quotient  (div_b_quo),
      .remainder ()
   );

   // Cursor arithmetic on the tracked row and column.
   always_comb begin
      is_print    = (item_ff.kind == KIND_PRINT);
      is_newline  = (item_ff.kind == KIND_NEWLINE);
      is_bs       = (item_ff.kind == KIND_BACKSPACE);
      bs_ok       = (cursor_ff >= floor_ff) && (cursor_ff != '0);
      col_is_zero = (col_ff == '0);
      col_dec     = col_is_zero ? cpl_ff - 1'b1 : col_ff - 1'b1;
      row_dec     = col_is_zero ? row_ff - 1'b1 : row_ff;
      draw_col    = is_bs ? col_dec : col_ff;
      draw_row    = is_bs ? row_dec[CoordW-1:0] : row_ff[CoordW-1:0];
      prod_x      = scale * draw_col;
      prod_y      = line_h * draw_row;
      draw_x      = cfg.left + prod_x[CoordW-1:0];
      draw_y      = cfg.top + prod_y[CoordW-1:0];

      inc_sum = {1'b0, cursor_ff} + (CursorW+1)'(1);
      nl_sum  = {1'b0, cursor_ff} + {{(CursorW-CoordW+1){1'b0}}, cpl_ff - col_ff};
      col_inc = {1'b0, col_ff} + (CoordW+1)'(1);

      new_cursor = cursor_ff;
      new_row    = row_ff;
      new_col    = col_ff;
      if (is_print) begin
         new_cursor = inc_sum[CursorW-1:0];
         if (inc_sum[CursorW]) begin
            new_row = '0;
            new_col = '0;
         end else if (col_inc == {1'b0, cpl_ff}) begin
            new_row = row_ff + 1'b1;
            new_col = '0;
         end else begin
            new_col = col_inc[CoordW-1:0];
         end
      end else if (is_newline) begin
         new_cursor = nl_sum[CursorW-1:0];
         if (nl_sum[CursorW]) begin
            new_row = '0;
            new_col = nl_sum[CoordW-1:0];
         end else begin
            new_row = row_ff + 1'b1;
            new_col = '0;
         end
      end
      scroll_need = (({1'b0, new_row} + (CursorW+1)'(1)) >=
                     {{(CursorW-CoordW+1){1'b0}}, lines_ff});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = cfg_dirty ? ST_DIV_CFG : ST_EXEC;
            end
         end
         ST_DIV_CFG: begin
            if (div_a_done) begin
               state_in = ST_POS_START;
            end
         end
         ST_POS_START: begin
            state_in = ST_DIV_POS;
         end
         ST_DIV_POS: begin
            if (div_a_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = (!is_bs && scroll_need) ? ST_SCROLL : ST_IDLE;
            end
         end
         ST_SCROLL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and result register updates for each state.
   always_comb begin
      item_in       = item_ff;
      cursor_in     = cursor_ff;
      floor_in      = floor_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cpl_in        = cpl_ff;
      lines_in      = lines_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_glyph_in  = out_glyph_ff;
      out_size_in   = out_size_ff;
      out_scroll_in = out_scroll_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in = q_item;
            end
         end
         ST_DIV_CFG: begin
            if (div_a_done) begin
               cpl_in   = (div_a_quo[CoordW-1:0] == '0) ? CoordW'(1) : div_a_quo[CoordW-1:0];
               lines_in = div_b_quo[CoordW-1:0];
            end
         end
         ST_POS_START: begin
         end
         ST_DIV_POS: begin
            if (div_a_done) begin
               row_in = div_a_quo;
               col_in = div_a_rem;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               if (is_bs) begin
                  if (bs_ok) begin
                     cursor_in     = cursor_ff - 1'b1;
                     row_in        = row_dec;
                     col_in        = col_dec;
                     out_valid_in  = 1'b1;
                     out_kind_in   = CmdDraw;
                     out_x_in      = draw_x;
                     out_y_in      = draw_y;
                     out_glyph_in  = CharSpace;
                     out_size_in   = scale;
                     out_scroll_in = '0;
                     out_last_in   = 1'b1;
                  end
               end else begin
                  cursor_in = new_cursor;
                  row_in    = new_row;
                  col_in    = new_col;
                  if (is_print) begin
                     out_valid_in  = 1'b1;
                     out_kind_in   = CmdDraw;
                     out_x_in      = draw_x;
                     out_y_in      = draw_y;
                     out_glyph_in  = item_ff.code;
                     out_size_in   = scale;
                     out_scroll_in = '0;
                     out_last_in   = !scroll_need;
                  end
               end
            end
         end
         ST_SCROLL: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = CmdScroll;
               out_x_in      = '0;
               out_y_in      = '0;
               out_glyph_in  = '0;
               out_size_in   = scale;
               out_scroll_in = line_h;
               out_last_in   = 1'b1;
               // The cursor is at least one line in exactly when its row is not zero.
               if (row_ff != '0) begin
                  cursor_in = cursor_ff - {{(CursorW-CoordW){1'b0}}, cpl_ff};
                  row_in    = row_ff - 1'b1;
               end else begin
                  cursor_in = '0;
                  col_in    = '0;
               end
               if (floor_ff >= {{(CursorW-CoordW){1'b0}}, cpl_ff}) begin
                  floor_in = floor_ff - {{(CursorW-CoordW){1'b0}}, cpl_ff};
               end else begin
                  floor_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= ResetCursor;
         floor_ff     <= ResetFloor;
         row_ff       <= '0;
         col_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         floor_ff     <= floor_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff       <= item_in;
      cpl_ff        <= cpl_in;
      lines_ff      <= lines_in;
      out_kind_ff   <= out_kind_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_glyph_ff  <= out_glyph_in;
      out_size_ff   <= out_size_in;
      out_scroll_ff <= out_scroll_in;
      out_last_ff   <= out_last_in;
   end

endmodule

// ----- rtl/text_console_cursor_renderer.sv -----
// Text console cursor renderer.
// The req channel takes one character per item (valid/stall). Printable codes
// produce a draw command at the cursor cell, newline moves to the next line,
// backspace erases one cell back unless the cursor is below the edit floor or at
// zero, and NUL is dropped. When the cursor reaches the last line a scroll
// command follows, with last set on the final command of each item.
// The rsp channel carries the commands (valid/stall) from an output register.
// The csr channel (valid/ready, always ready) writes the area and scale
// registers; writes are to be made while the block is idle, which the block itself does not enforce.
// A taken item is held in the item register; its first command then goes to the output register.
// The back end finishes one item before it takes the next, stepping through its
// states (take, execute, optional scroll) and holding while rsp stalls.
// The first item after reset or after any register write waits on the iterative
// dividers: 24 steps for chars per line and lines, then 24 steps for the cursor's
// row and column.
// A stalled rsp holds its command; the two-entry queue and the front holding
// register keep taking items until they fill, then req_stall rises.
// Reset clears the cursor to 0, the edit floor to 1, and the area and scale
// registers to their defaults.
module text_console_cursor_renderer import tccr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CharW-1:0]     req_char_code,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_command_kind,
   output logic [CoordW-1:0]    rsp_pos_x,
   output logic [CoordW-1:0]    rsp_pos_y,
   output logic [CharW-1:0]     rsp_glyph,
   output logic [ScaleW-1:0]    rsp_cell_size,
   output logic [ScrollW-1:0]   rsp_scroll_pixels,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     cfg_dirty_ff, cfg_dirty_in;
   logic     cfg_clear;
   logic     csr_write;
   logic     q_push, q_full, q_pop, q_valid;
   item_type push_item, head_item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register writes; any write marks the derived geometry stale.
   always_comb begin
      cfg_in       = cfg_ff;
      cfg_dirty_in = cfg_clear ? 1'b0 : cfg_dirty_ff;
      if (csr_write) begin
         cfg_dirty_in = 1'b1;
         case (reg_index_type'(csr_index))
            REG_AREA_LEFT:   cfg_in.left   = csr_data[CoordW-1:0];
            REG_AREA_TOP:    cfg_in.top    = csr_data[CoordW-1:0];
            REG_AREA_RIGHT:  cfg_in.right  = csr_data[CoordW-1:0];
            REG_AREA_BOTTOM: cfg_in.bottom = csr_data[CoordW-1:0];
            REG_GLYPH_SCALE: cfg_in.scale  = csr_data[ScaleW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left   <= ResetLeft;
         cfg_ff.top    <= ResetTop;
         cfg_ff.right  <= ResetRight;
         cfg_ff.bottom <= ResetBottom;
         cfg_ff.scale  <= ResetScale;
         cfg_dirty_ff  <= 1'b1;
      end else begin
         cfg_ff       <= cfg_in;
         cfg_dirty_ff <= cfg_dirty_in;
      end
   end

   tccr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .q_push        (q_push),
      .q_item        (push_item),
      .q_full        (q_full)
   );

   tccr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   tccr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cfg_dirty         (cfg_dirty_ff),
      .cfg_clear         (cfg_clear),
      .q_valid           (q_valid),
      .q_item            (head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command_kind  (rsp_command_kind),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_glyph         (rsp_glyph),
      .rsp_cell_size     (rsp_cell_size),
      .rsp_scroll_pixels (rsp_scroll_pixels),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- rtl/tccr_checker.sv -----
module tccr_checker import tccr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_command_kind,
   input logic [CoordW-1:0]  rsp_pos_x,
   input logic [CoordW-1:0]  rsp_pos_y,
   input logic [CharW-1:0]   rsp_glyph,
   input logic [ScaleW-1:0]  rsp_cell_size,
   input logic [ScrollW-1:0] rsp_scroll_pixels,
   input logic               rsp_last
);

   // A stalled item stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // A scroll is always the final command of its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command_kind == CmdScroll) |-> rsp_last)
      else $error("scroll item without last");

   // A scroll carries no cell position or glyph, and a nonzero line height.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command_kind == CmdScroll) |->
         (rsp_pos_x == '0) && (rsp_pos_y == '0) && (rsp_glyph == '0) &&
         (rsp_scroll_pixels != '0))
      else $error("scroll item with draw fields");

   // A draw carries no scroll amount and a usable cell size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command_kind == CmdDraw) |->
         (rsp_scroll_pixels == '0) && (rsp_cell_size != '0))
      else $error("draw item with bad size fields");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp item offered after reset");

endmodule

bind text_console_cursor_renderer tccr_checker u_checker (.*);

// ----- sim/testbench.sv -----
module testbench;
   import tccr_pkg::*;

   // Command as it leaves the block, one field per output port.
   typedef struct packed {
      logic              kind;
      logic [CoordW-1:0] pos_x;
      logic [CoordW-1:0] pos_y;
      logic [CharW-1:0]  glyph;
      logic [ScaleW-1:0] cell_size;
      logic [ScrollW-1:0] scroll_pixels;
      logic              last;
   } render_cmd_type;

   localparam int IdleSettleCycles = 120;
   localparam int HoldOffCycles    = 400;
   localparam int RandomPhases     = 6;
   localparam int ItemsPerPhase    = 80;
   localparam int MaxPrintedErrors = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CharW-1:0]     req_char_code;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_command_kind;
   logic [CoordW-1:0]    rsp_pos_x;
   logic [CoordW-1:0]    rsp_pos_y;
   logic [CharW-1:0]     rsp_glyph;
   logic [ScaleW-1:0]    rsp_cell_size;
   logic [ScrollW-1:0]   rsp_scroll_pixels;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_data;

   // Shadow copy of the console state and the area registers.
   logic [CoordW-1:0]  cfg_left;
   logic [CoordW-1:0]  cfg_top;
   logic [CoordW-1:0]  cfg_right;
   logic [CoordW-1:0]  cfg_bottom;
   logic [ScaleW-1:0]  cfg_scale;
   logic [CursorW-1:0] cursor_pos;
   logic [CursorW-1:0] edit_floor;

   render_cmd_type pending_cmds[$];

   int mismatches    = 0;
   int cmds_checked  = 0;
   int items_sent    = 0;
   int areas_set     = 0;
   int burst_left    = 0;
   bit hold_off_req  = 1'b0;

   text_console_cursor_renderer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command_kind  (rsp_command_kind),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_glyph         (rsp_glyph),
      .rsp_cell_size     (rsp_cell_size),
      .rsp_scroll_pixels (rsp_scroll_pixels),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run must never take this long, even with every stall at its worst.
   initial begin
      #5_000_000;
      $display("FAIL text_console_cursor_renderer");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MaxPrintedErrors) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("command %0d %s: got %0d, expected %0d",
                                   cmds_checked, name, got, want));
      end
   endtask

   // Draw command for the cell under the cursor.
   function automatic render_cmd_type cell_cmd(input logic [CharW-1:0] glyph,
                                               input int unsigned sc, cpl, lh);
      render_cmd_type c;
      c.kind          = CmdDraw;
      c.pos_x         = CoordW'(cfg_left + sc * (cursor_pos % cpl));
      c.pos_y         = CoordW'(64'(cfg_top) + 64'(lh) * 64'(cursor_pos / cpl));
      c.glyph         = glyph;
      c.cell_size     = ScaleW'(sc);
      c.scroll_pixels = '0;
      c.last          = 1'b0;
      return c;
   endfunction

   // Advance the shadow console by one character and queue its commands.
   task automatic render_char(input logic [CharW-1:0] code);
      int unsigned sc, w, h, cpl, lh, lines;
      render_cmd_type cmds[$];
      render_cmd_type scroll;
      sc    = (cfg_scale == 0) ? 1 : cfg_scale;
      w     = (cfg_right >= cfg_left) ? cfg_right - cfg_left : 0;
      h     = (cfg_bottom >= cfg_top) ? cfg_bottom - cfg_top : 0;
      cpl   = w / sc;
      lh    = 2 * sc + 2;
      lines = h / lh;
      if (cpl == 0) begin
         cpl = 1;
      end
      if (code == CharBackspace) begin
         // Erase one cell back, unless below the edit floor or at the origin.
         if (cursor_pos >= edit_floor && cursor_pos != 0) begin
            cursor_pos = cursor_pos - 1'b1;
            cmds.push_back(cell_cmd(CharSpace, sc, cpl, lh));
         end
      end else if (code != CharNul) begin
         if (code == CharNewline) begin
            cursor_pos = CursorW'(cursor_pos + (cpl - cursor_pos % cpl));
         end else begin
            cmds.push_back(cell_cmd(code, sc, cpl, lh));
            cursor_pos = cursor_pos + 1'b1;
         end
         // On the last line the area scrolls and everything moves up a line.
         if (cursor_pos / cpl + 1 >= lines) begin
            scroll               = '0;
            scroll.kind          = CmdScroll;
            scroll.cell_size     = ScaleW'(sc);
            scroll.scroll_pixels = ScrollW'(lh);
            cmds.push_back(scroll);
            cursor_pos = (cursor_pos >= cpl) ? CursorW'(cursor_pos - cpl) : '0;
            edit_floor = (edit_floor >= cpl) ? CursorW'(edit_floor - cpl) : '0;
         end
      end
      if (cmds.size() > 0) begin
         cmds[cmds.size() - 1].last = 1'b1;
      end
      foreach (cmds[i]) begin
         pending_cmds.push_back(cmds[i]);
      end
   endtask

   // Offer one item and hold it until taken; bursts end in a random gap.
   task automatic send_char(input logic [CharW-1:0] code);
      int gap;
      req_valid     <= 1'b1;
      req_char_code <= code;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      render_char(code);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop sending and let every outstanding item finish.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) begin
         @(posedge clock);
      end
      repeat (IdleSettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexW-1:0] index,
                            input logic [CsrDataW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (index)
         REG_AREA_LEFT:   cfg_left   = data;
         REG_AREA_TOP:    cfg_top    = data;
         REG_AREA_RIGHT:  cfg_right  = data;
         REG_AREA_BOTTOM: cfg_bottom = data;
         REG_GLYPH_SCALE: cfg_scale  = data[ScaleW-1:0];
         default: ;
      endcase
   endtask

   // Program the whole area while idle; unused indexes get noise too.
   task automatic set_area(input logic [CoordW-1:0] left, top, right, bottom,
                           input logic [ScaleW-1:0] scale);
      wait_for_idle();
      write_reg(REG_AREA_LEFT, left);
      write_reg(REG_AREA_TOP, top);
      write_reg(REG_AREA_RIGHT, right);
      write_reg(REG_AREA_BOTTOM, bottom);
      write_reg(REG_GLYPH_SCALE, {6'($urandom_range(0, 63)), scale});
      for (int idx = int'(REG_GLYPH_SCALE) + 1; idx < (1 << CsrIndexW); idx++) begin
         write_reg(CsrIndexW'(idx), CsrDataW'($urandom));
      end
      csr_valid <= 1'b0;
      areas_set++;
   endtask

   // Reset settings: every operation, plus a backspace at the origin.
   task automatic test_default_area();
      send_char(CharBackspace);
      send_char(8'h41);
      send_char(8'hFF);
      send_char(8'h01);
      send_char(8'h7F);
      send_char(CharBackspace);
      send_char(CharNul);
      send_char(CharNewline);
   endtask

   // Five columns and four lines, so a few newlines reach the scroll.
   task automatic test_scrolling();
      set_area(12'd0, 12'd0, 12'd20, 12'd40, 6'd4);
      send_char(CharNewline);
      send_char(CharNewline);
      send_char(CharNewline);
      send_char(8'h78);
      send_char(CharBackspace);
      send_char(CharBackspace);
   endtask

   // Inverted area with zero scale, then a wide area too short for a line,
   // where each scroll clamps the cursor at zero.
   task automatic test_degenerate_area();
      set_area(12'd100, 12'd200, 12'd50, 12'd150, 6'd0);
      send_char(8'h5A);
      send_char(CharNewline);
      send_char(CharBackspace);
      set_area(12'd0, 12'd0, 12'd4095, 12'd5, 6'd63);
      send_char(8'h71);
      send_char(CharBackspace);
   endtask

   // A far corner with a single column, so the carried cursor row wraps y.
   task automatic test_coordinate_wrap();
      set_area(12'd0, 12'd0, 12'd4095, 12'd4095, 6'd1);
      repeat (12) send_char(CharNewline);
      set_area(12'd4095, 12'd4000, 12'd4095, 12'd4095, 6'd63);
      send_char(8'h2A);
      send_char(8'h80);
   endtask

   // The receiver holds off while the sender keeps offering items.
   task automatic test_output_backpressure();
      set_area(12'd10, 12'd10, 12'd200, 12'd300, 6'd5);
      hold_off_req = 1'b1;
      burst_left   = 30;
      repeat (20) send_char(CharW'($urandom_range(33, 126)));
      wait_for_idle();
   endtask

   function automatic logic [CharW-1:0] random_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         return CharNewline;
      end else if (r < 26) begin
         return CharBackspace;
      end else if (r < 29) begin
         return CharNul;
      end
      return CharW'($urandom_range(0, 255));
   endfunction

   // Random text over a series of areas, extremes first.
   task automatic test_random_text();
      int sent;
      logic [CoordW-1:0] left, top;
      logic [CharW-1:0] code;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         left = CoordW'($urandom_range(0, 4095));
         top  = CoordW'($urandom_range(0, 4095));
         case (phase)
            0: set_area(12'd0, 12'd0, 12'd4095, 12'd4095, 6'd1);
            1: set_area(left, top, CoordW'(left + $urandom_range(0, 4095)),
                        CoordW'(top + $urandom_range(0, 700)), 6'd63);
            2: set_area(12'd0, 12'd0, 12'd0, 12'd0, ScaleW'($urandom_range(0, 63)));
            default: set_area(left, top, CoordW'(left + $urandom_range(0, 300)),
                              CoordW'(top + $urandom_range(0, 200)),
                              ($urandom_range(0, 1) == 0) ? ScaleW'($urandom_range(0, 8))
                                                          : ScaleW'($urandom_range(0, 63)));
         endcase
         sent = 0;
         while (sent < ItemsPerPhase) begin
            code = random_char();
            send_char(code);
            if (code != CharNul) begin
               sent++;
            end
            // Now and then the sender waits for the block to drain.
            if ($urandom_range(0, 39) == 0) begin
               wait_for_idle();
            end
         end
      end
   endtask

   // Receiver stall pattern: segments of differing stall density, plus
   // a long hold-off on request.
   initial begin
      int hold_left;
      int seg_left;
      int stall_pct;
      hold_left = 0;
      seg_left  = 0;
      stall_pct = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HoldOffCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(10, 150);
               case ($urandom_range(0, 2))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  default: stall_pct = 70;
               endcase
            end
            seg_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Compare each accepted command with the oldest expected one.
   initial begin
      render_cmd_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_cmds.size() == 0) begin
               report_mismatch("command arrived with none expected");
            end else begin
               want = pending_cmds.pop_front();
               check_field("command_kind", rsp_command_kind, want.kind);
               check_field("pos_x", rsp_pos_x, want.pos_x);
               check_field("pos_y", rsp_pos_y, want.pos_y);
               check_field("glyph", rsp_glyph, want.glyph);
               check_field("cell_size", rsp_cell_size, want.cell_size);
               check_field("scroll_pixels", rsp_scroll_pixels, want.scroll_pixels);
               check_field("last", rsp_last, want.last);
               cmds_checked++;
            end
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_char_code <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      cfg_left   = ResetLeft;
      cfg_top    = ResetTop;
      cfg_right  = ResetRight;
      cfg_bottom = ResetBottom;
      cfg_scale  = ResetScale;
      cursor_pos = ResetCursor;
      edit_floor = ResetFloor;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_default_area();
      test_scrolling();
      test_degenerate_area();
      test_coordinate_wrap();
      test_output_backpressure();
      test_random_text();
      wait_for_idle();

      if (pending_cmds.size() != 0) begin
         report_mismatch($sformatf("%0d expected commands never arrived",
                                   pending_cmds.size()));
      end
      $display("Sent %0d characters over %0d area settings and checked %0d commands.",
               items_sent, areas_set, cmds_checked);
      $display("Included scrolls, erases, degenerate areas and a long output hold-off.");
      if (mismatches == 0) begin
         $display("PASS text_console_cursor_renderer");
      end else begin
         $display("FAIL text_console_cursor_renderer");
      end
      $finish;
   end

endmodule
